// ----- rtl/mhpq_pkg.sv -----
// Shared constants and types for the max-heap priority queue.
// Holds the command and status codes and the fixed stream field widths.
// No dependencies.
package mhpq_pkg;

  typedef logic [1:0] status_t;

  localparam logic    CMD_PUSH     = 1'b0;
  localparam logic    CMD_POP      = 1'b1;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 7;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 40;
  localparam int M_PAD_W    = M_TDATA_W - VALUE_W - COUNT_W;

endpackage

// ----- rtl/mhpq_store.sv -----
// Heap entry store: one write port and two read ports with registered read data.
// Used by max_heap_priority_queue; no package dependency.
module mhpq_store #(
  parameter int AW = 7,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/max_heap_priority_queue.sv -----
// Top level of the binary max-heap priority queue: sequencer, count and result register.
// Depends on mhpq_pkg and mhpq_store.
//
//  Channel  Dir  Handshake          Contents
//  s_*      in   s_tvalid/s_tready  tuser: cmd; tdata: push_value
//  m_*      out  m_tvalid/m_tready  tuser: status; tdata: popped_value, entry_count
//
// One item is taken at a time. A push sifts the new value up and a pop sifts the last
// entry down from the root; each level is one read-compare-write through the store's
// registered read ports, and the swaps made are at most one less than the tree depth.
// A push into an empty queue, a rejected push and a pop on an empty queue skip the
// sift, and so does a pop that leaves at most one entry.
// Reset empties the queue at once; heap slots are not cleared.
// A result waits in the output register while m_tready is low, and the next item
// is taken as soon as the result has been loaded there.
module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY   = 127,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // [31:0] push_value
  input  logic                 s_tuser,  // [0] cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // [31:0] popped_value, [38:32] entry_count
  output logic [1:0]           m_tuser   // [1:0] status
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UP     = 3'd1;
  localparam logic [2:0] ST_POPLD  = 3'd2;
  localparam logic [2:0] ST_DOWN   = 3'd3;
  localparam logic [2:0] ST_PLACE  = 3'd4;
  localparam logic [2:0] ST_RESULT = 3'd5;

  logic [2:0]            state, state_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic [CW-1:0]         node, node_next;
  logic [DATA_WIDTH-1:0] val, val_next;
  logic [DATA_WIDTH-1:0] popped, popped_next;
  status_t               status, status_next;
  logic                  out_load;

  logic                  we;
  logic [CW-1:0]         waddr, raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] wdata, rdata_a, rdata_b;

  logic [DATA_WIDTH-1:0] in_val;
  logic [CW-1:0]         cnt_inc, cnt_dec, parent_idx, pick_idx;
  logic [CW:0]           kid_l, next_kid;
  logic                  has_right;
  logic [DATA_WIDTH-1:0] pick_val;

  function automatic logic greater(input logic [DATA_WIDTH-1:0] x,
                                   input logic [DATA_WIDTH-1:0] y);
    return $signed(x) > $signed(y);
  endfunction

  mhpq_store #(
    .AW(CW),
    .DW(DATA_WIDTH)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  assign s_tready   = (state == ST_IDLE);
  assign in_val     = DATA_WIDTH'(s_tdata);
  assign cnt_inc    = cnt + 1'b1;
  assign cnt_dec    = cnt - 1'b1;
  assign parent_idx = node >> 1;
  assign kid_l      = {node, 1'b0};
  assign has_right  = (kid_l + 1'b1) <= {1'b0, cnt};
  assign pick_idx   = (has_right && !greater(rdata_a, rdata_b)) ? CW'(kid_l + 1'b1)
                                                                 : CW'(kid_l);
  assign pick_val   = (has_right && !greater(rdata_a, rdata_b)) ? rdata_b : rdata_a;
  assign next_kid   = {pick_idx, 1'b0};

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    node_next   = node;
    val_next    = val;
    popped_next = popped;
    status_next = status;
    out_load    = 1'b0;
    we          = 1'b0;
    waddr       = node;
    wdata       = val;
    raddr_a     = node;
    raddr_b     = cnt;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          popped_next = '0;
          status_next = STATUS_OK;
          val_next    = in_val;
          if (s_tuser == CMD_PUSH) begin
            if (cnt == CW'(CAPACITY)) begin
              status_next = STATUS_FULL;
              state_next  = ST_RESULT;
            end else begin
              cnt_next  = cnt_inc;
              node_next = cnt_inc;
              if (cnt == '0) begin
                we         = 1'b1;
                waddr      = CW'(1);
                wdata      = in_val;
                state_next = ST_RESULT;
              end else begin
                raddr_a    = cnt_inc >> 1;
                state_next = ST_UP;
              end
            end
          end else begin
            if (cnt == '0) begin
              status_next = STATUS_EMPTY;
              state_next  = ST_RESULT;
            end else begin
              raddr_a    = CW'(1);
              raddr_b    = cnt;
              node_next  = CW'(1);
              state_next = ST_POPLD;
            end
          end
        end
      end
      ST_UP: begin
        if (greater(val, rdata_a)) begin
          we        = 1'b1;
          waddr     = node;
          wdata     = rdata_a;
          node_next = parent_idx;
          if (parent_idx == CW'(1)) begin
            state_next = ST_PLACE;
          end else begin
            raddr_a = parent_idx >> 1;
          end
        end else begin
          we         = 1'b1;
          state_next = ST_RESULT;
        end
      end
      ST_POPLD: begin
        popped_next = rdata_a;
        val_next    = rdata_b;
        cnt_next    = cnt_dec;
        if (cnt_dec < CW'(2)) begin
          we         = 1'b1;
          waddr      = CW'(1);
          wdata      = rdata_b;
          state_next = ST_RESULT;
        end else begin
          raddr_a    = CW'(2);
          raddr_b    = CW'(3);
          state_next = ST_DOWN;
        end
      end
      ST_DOWN: begin
        if (greater(pick_val, val)) begin
          we        = 1'b1;
          waddr     = node;
          wdata     = pick_val;
          node_next = pick_idx;
          if (next_kid > {1'b0, cnt}) begin
            state_next = ST_PLACE;
          end else begin
            raddr_a = CW'(next_kid);
            raddr_b = CW'(next_kid + 1'b1);
          end
        end else begin
          we         = 1'b1;
          state_next = ST_RESULT;
        end
      end
      ST_PLACE: begin
        we         = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    node   <= node_next;
    val    <= val_next;
    popped <= popped_next;
    status <= status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {M_PAD_W'(0), COUNT_W'(cnt), VALUE_W'(popped)};
      m_tuser <= status;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken before the first finished");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> cnt == $past(cnt) || cnt == $past(cnt) + 1'b1 ||
                    cnt == $past(cnt) - 1'b1)
    else $error("entry count moved by more than one");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STATUS_OK |-> m_tdata[VALUE_W-1:0] == '0)
    else $error("failed operation returned a value");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !m_tvalid || m_tready)
    else $error("result overwrote a pending result");
`endif

endmodule

// ----- dv/heap_result_checker.sv -----
// Result checker for the max-heap priority queue: watches both stream channels,
// keeps its own copy of the heap and compares each result item with the prediction.
// Depends on mhpq_pkg.
module heap_result_checker
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = 127
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic [1:0]           m_tuser,
  output int                   pending,
  output int                   failures
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VALUE_W-1:0] popped;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } heap_result_t;

  logic signed [VALUE_W-1:0] heap_slots [1:CAPACITY];
  int                        heap_count;
  heap_result_t              expected_results [$];

  function automatic heap_result_t heap_apply(input logic cmd, input logic [VALUE_W-1:0] value);
    heap_result_t              r;
    int                        node;
    int                        kid;
    logic signed [VALUE_W-1:0] tmp;
    r.popped = '0;
    r.status = STATUS_OK;
    if (cmd == CMD_PUSH) begin
      if (heap_count >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        heap_count++;
        heap_slots[heap_count] = value;
        node = heap_count;
        while (node > 1 && heap_slots[node] > heap_slots[node / 2]) begin
          tmp = heap_slots[node];
          heap_slots[node] = heap_slots[node / 2];
          heap_slots[node / 2] = tmp;
          node = node / 2;
        end
      end
    end else begin
      if (heap_count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.popped = heap_slots[1];
        heap_slots[1] = heap_slots[heap_count];
        heap_count--;
        node = 1;
        while (1) begin
          kid = node * 2;
          if (kid > heap_count) break;
          if (kid + 1 <= heap_count && !(heap_slots[kid] > heap_slots[kid + 1])) kid++;
          if (!(heap_slots[kid] > heap_slots[node])) break;
          tmp = heap_slots[kid];
          heap_slots[kid] = heap_slots[node];
          heap_slots[node] = tmp;
          node = kid;
        end
      end
    end
    r.count = heap_count[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    heap_result_t e;
    if (rst) begin
      heap_count = 0;
      expected_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(heap_apply(s_tuser, s_tdata[VALUE_W-1:0]));
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("Result item arrived with no expected result waiting.");
          failures++;
        end else begin
          e = expected_results.pop_front();
          if (m_tdata[VALUE_W-1:0] !== e.popped) begin
            $error("popped_value mismatch: expected %0d, actual %0d",
                   $signed(e.popped), $signed(m_tdata[VALUE_W-1:0]));
            failures++;
          end
          if (m_tuser !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, m_tuser);
            failures++;
          end
          if (m_tdata[VALUE_W+COUNT_W-1:VALUE_W] !== e.count) begin
            $error("entry_count mismatch: expected %0d, actual %0d",
                   e.count, m_tdata[VALUE_W+COUNT_W-1:VALUE_W]);
            failures++;
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ----- dv/max_heap_priority_queue_tb.sv -----
// Testbench top for the max-heap priority queue: clock, reset, stimulus and verdict.
// Depends on mhpq_pkg, max_heap_priority_queue and heap_result_checker.
module max_heap_priority_queue_tb;
  import mhpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY   = 127;
  localparam int RAND_ITEMS = 1100;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 s_tuser  = CMD_PUSH;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0]           m_tuser;
  int                   pending;
  int                   failures;

  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int level    = 0;
  int items_sent = 0;

  max_heap_priority_queue #(.CAPACITY(CAPACITY), .DATA_WIDTH(VALUE_W)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  heap_result_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .pending(pending), .failures(failures)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VALUE_W-1:0] next_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom;
    if (sel < 7) return VALUE_W'($signed($urandom_range(0, 8)) - 4);
    if (sel < 8) begin
      case ($urandom_range(0, 3))
        0: return {1'b0, {(VALUE_W-1){1'b1}}};
        1: return {1'b1, {(VALUE_W-1){1'b0}}};
        2: return '0;
        default: return '1;
      endcase
    end
    if (sel < 9) return $urandom & $urandom;
    return $urandom | $urandom;
  endfunction

  // Receiver: random ready pattern, steady ready while calm, one long hold-off on request.
  initial begin
    bit ready_val;
    int run_len;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (400) begin
          @(posedge clk);
          m_tready <= 1'b0;
        end
      end else if (calm) begin
        @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        ready_val = ($urandom_range(0, 2) != 0);
        run_len = ready_val ? $urandom_range(1, 30) : pick_gap() + 1;
        repeat (run_len) begin
          @(posedge clk);
          m_tready <= ready_val;
        end
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [VALUE_W-1:0] value);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (cmd == CMD_PUSH) begin
      if (level < CAPACITY) level++;
    end else if (level > 0) begin
      level--;
    end
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int          phase;
    phase_kind_t kind;
    int          sel;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pop, field extremes, equal keys, drain and pop past empty.
    send_item(CMD_POP, 32'h1234_5678);
    send_item(CMD_PUSH, 32'h0000_0000);
    send_item(CMD_PUSH, 32'h7fff_ffff);
    send_item(CMD_PUSH, 32'h8000_0000);
    send_item(CMD_PUSH, 32'hffff_ffff);
    send_item(CMD_PUSH, 32'h0000_0001);
    send_item(CMD_PUSH, 32'h0000_0005);
    send_item(CMD_PUSH, 32'h0000_0005);
    send_item(CMD_PUSH, 32'h0000_0003);
    send_item(CMD_PUSH, 32'h0000_0003);
    repeat (10) send_item(CMD_POP, $urandom);

    phase = 0;
    while (items_sent < RAND_ITEMS + 20) begin
      calm = (phase > 1) && ($urandom_range(0, 3) == 0);
      if (phase == 0) begin
        kind = PH_FILL;
        hold_req = 1'b1;
      end else if (phase == 1) begin
        kind = PH_DRAIN;
      end else begin
        sel = $urandom_range(0, 9);
        kind = (sel < 3) ? PH_FILL : (sel < 6) ? PH_DRAIN : PH_MIX;
      end
      case (kind)
        PH_FILL: begin
          while (level < CAPACITY) send_item(CMD_PUSH, next_value());
          repeat ($urandom_range(1, 4)) send_item(CMD_PUSH, next_value());
        end
        PH_DRAIN: begin
          while (level > 0) send_item(CMD_POP, next_value());
          repeat ($urandom_range(1, 4)) send_item(CMD_POP, next_value());
        end
        default: begin
          repeat ($urandom_range(20, 100))
            send_item($urandom_range(0, 1) ? CMD_POP : CMD_PUSH, next_value());
        end
      endcase
      if (phase == 0) wait_results();
      phase++;
    end
    calm = 1'b0;

    wait_results();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
